FILE: sv/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent on the same edge
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/gfd_pkg.sv
// shared types, constants and helpers of the gamepad frame deframer
package gfd_pkg;

  localparam int AXIS_W = 8;
  localparam int DZ_W   = 7;
  localparam int BTN_W  = 16;
  localparam int POS_W  = 3;
  localparam int CFG_W  = 8;
  localparam int CAP_N  = 5;

  localparam logic [AXIS_W-1:0] HEADER_BYTE = 8'hAA;
  localparam logic [POS_W-1:0]  POS_HUNT    = 3'd0;
  localparam logic [POS_W-1:0]  POS_FIRST   = 3'd1;
  localparam logic [POS_W-1:0]  POS_LAST    = 3'd6;

  typedef enum logic [CFG_W-1:0] {
    REG_LEFT_X_DZ  = 8'd0,
    REG_LEFT_Y_DZ  = 8'd1,
    REG_RIGHT_X_DZ = 8'd2,
    REG_RIGHT_Y_DZ = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DZ_W-1:0] left_x;
    logic [DZ_W-1:0] left_y;
    logic [DZ_W-1:0] right_x;
    logic [DZ_W-1:0] right_y;
  } deadzone_t;

  typedef struct packed {
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
    logic [BTN_W-1:0]  buttons;
  } raw_frame_t;

  // zero an axis whose magnitude does not exceed the dead zone
  function automatic logic [AXIS_W-1:0] apply_deadzone(input logic [AXIS_W-1:0] raw,
                                                       input logic [DZ_W-1:0] dz);
    logic [AXIS_W-1:0] mag;
    mag = raw[AXIS_W-1] ? AXIS_W'(-raw) : raw;
    return (mag > {1'b0, dz}) ? raw : '0;
  endfunction

endpackage

FILE: sv/gfd_rx_if.sv
// received byte channel
interface gfd_rx_if;
  logic                          valid;
  logic                          ready;
  logic [gfd_pkg::AXIS_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/gfd_frame_if.sv
// decoded frame channel
interface gfd_frame_if;
  logic                              valid;
  logic                              ready;
  logic signed [gfd_pkg::AXIS_W-1:0] left_x;
  logic signed [gfd_pkg::AXIS_W-1:0] left_y;
  logic signed [gfd_pkg::AXIS_W-1:0] right_x;
  logic signed [gfd_pkg::AXIS_W-1:0] right_y;
  logic [gfd_pkg::BTN_W-1:0]         button_mask;
  logic                              left_moved;
  logic                              right_moved;

  modport source (output valid, output left_x, output left_y, output right_x,
                  output right_y, output button_mask, output left_moved,
                  output right_moved, input ready);
  modport sink   (input valid, input left_x, input left_y, input right_x,
                  input right_y, input button_mask, input left_moved,
                  input right_moved, output ready);
endinterface

FILE: sv/gfd_cfg_if.sv
// configuration write channel
interface gfd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gfd_pkg::CFG_W-1:0]    index;
  logic [gfd_pkg::CFG_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/gfd_cfg_regs.sv
// dead zone register bank
module gfd_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  gfd_cfg_if.sink             cfg,
  output gfd_pkg::deadzone_t  dz
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dz <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        gfd_pkg::REG_LEFT_X_DZ:  dz.left_x  <= cfg.data[gfd_pkg::DZ_W-1:0];
        gfd_pkg::REG_LEFT_Y_DZ:  dz.left_y  <= cfg.data[gfd_pkg::DZ_W-1:0];
        gfd_pkg::REG_RIGHT_X_DZ: dz.right_x <= cfg.data[gfd_pkg::DZ_W-1:0];
        gfd_pkg::REG_RIGHT_Y_DZ: dz.right_y <= cfg.data[gfd_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/gfd_capture.sv
// header hunt, frame position and captured frame bytes
module gfd_capture (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [gfd_pkg::AXIS_W-1:0]  rx_byte,
  output logic                        at_last,
  output logic                        done,
  output gfd_pkg::raw_frame_t         raw
);

  logic [gfd_pkg::POS_W-1:0]  pos;
  logic [gfd_pkg::POS_W-1:0]  pos_next;
  logic [gfd_pkg::AXIS_W-1:0] captured [gfd_pkg::CAP_N];
  logic [gfd_pkg::POS_W-1:0]  cap_idx;
  logic                       hunting;

  assign hunting = (pos == gfd_pkg::POS_HUNT) || (pos > gfd_pkg::POS_LAST);
  assign at_last = (pos == gfd_pkg::POS_LAST);
  assign done    = accept && at_last;
  assign cap_idx = pos - gfd_pkg::POS_FIRST;

  always_comb begin
    if (hunting) begin
      pos_next = (rx_byte == gfd_pkg::HEADER_BYTE) ? gfd_pkg::POS_FIRST : gfd_pkg::POS_HUNT;
    end else if (at_last) begin
      pos_next = gfd_pkg::POS_HUNT;
    end else begin
      pos_next = pos + gfd_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= gfd_pkg::POS_HUNT;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !hunting && !at_last) begin
      captured[cap_idx] <= rx_byte;
    end
  end

  assign raw.left_x  = captured[0];
  assign raw.left_y  = captured[1];
  assign raw.right_x = captured[2];
  assign raw.right_y = captured[3];
  assign raw.buttons = {rx_byte, captured[4]};

endmodule

FILE: sv/gfd_result.sv
// dead zone shaping and result register
module gfd_result (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  gfd_pkg::raw_frame_t  raw,
  input  gfd_pkg::deadzone_t   dz,
  gfd_frame_if.source          frame
);

  logic [gfd_pkg::AXIS_W-1:0] lx;
  logic [gfd_pkg::AXIS_W-1:0] ly;
  logic [gfd_pkg::AXIS_W-1:0] rx;
  logic [gfd_pkg::AXIS_W-1:0] ry;

  // y bytes arrive inverted
  assign lx = gfd_pkg::apply_deadzone(raw.left_x, dz.left_x);
  assign ly = gfd_pkg::apply_deadzone(~raw.left_y, dz.left_y);
  assign rx = gfd_pkg::apply_deadzone(raw.right_x, dz.right_x);
  assign ry = gfd_pkg::apply_deadzone(~raw.right_y, dz.right_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (load) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame.left_x      <= lx;
      frame.left_y      <= ly;
      frame.right_x     <= rx;
      frame.right_y     <= ry;
      frame.button_mask <= raw.buttons;
      frame.left_moved  <= (lx != '0) || (ly != '0);
      frame.right_moved <= (rx != '0) || (ry != '0);
    end
  end

endmodule

FILE: sv/gamepad_frame_deframer_deadzone.sv
// top level of the gamepad frame deframer with per-axis dead zones
// usage:
//   rx    - one received serial byte per transaction; bytes are dropped until
//           the header 0xAA, then the next six bytes form a frame
//   frame - one transaction per completed frame: four axes after their dead
//           zones, the 16-bit button mask and the left and right moved flags
//   cfg   - writes the four 7-bit dead zone registers (index 0 to 3, other
//           indexes are ignored); always ready, write only while idle
// result: the frame is registered as its sixth byte is accepted and is
//   valid on the output from the next cycle
// throughput: one byte per cycle while not stalled; a frame is seven bytes with its header
// stall: bytes that do not complete a frame are always taken; the last byte
//   of a frame waits only while the result register still holds an untaken
//   frame
// reset: returns to header hunt, clears the output valid and sets every
//   dead zone to zero
module gamepad_frame_deframer_deadzone (
  input  logic         clk,
  input  logic         rst,
  gfd_rx_if.sink       rx,
  gfd_frame_if.source  frame,
  gfd_cfg_if.sink      cfg
);

  `include "assert_macros.svh"

  gfd_pkg::deadzone_t  dz;
  gfd_pkg::raw_frame_t raw;
  logic                at_last;
  logic                done;
  logic                accept;

  assign rx.ready = !(at_last && frame.valid && !frame.ready);
  assign accept   = rx.valid && rx.ready;

  gfd_cfg_regs u_cfg_regs (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .dz  (dz)
  );

  gfd_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .at_last (at_last),
    .done    (done),
    .raw     (raw)
  );

  gfd_result u_result (
    .clk   (clk),
    .rst   (rst),
    .load  (done),
    .raw   (raw),
    .dz    (dz),
    .frame (frame)
  );

  `ASSERT_IMPLIES(a_valid_from_frame_end, clk, rst, $rose(frame.valid), $past(done), "output valid without a completed frame")
  `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst, !rx.ready, frame.valid && !frame.ready && at_last, "input stalled without a full result register")
  `ASSERT_IMPLIES(a_left_moved, clk, rst, frame.valid, frame.left_moved == ((frame.left_x != '0) || (frame.left_y != '0)), "left moved flag disagrees with axes")
  `ASSERT_IMPLIES(a_right_moved, clk, rst, frame.valid, frame.right_moved == ((frame.right_x != '0) || (frame.right_y != '0)), "right moved flag disagrees with axes")

endmodule
